### sv/crat_pkg.sv
// Shared types and constants for the code region address translation block.
// Used by crat_ctrl, crat_dp and code_region_address_translate; no dependencies.
package crat_pkg;

	// Default table depth and register reset value
	localparam int unsigned MAX_REGIONS_DEF = 4096;
	localparam logic [63:0] KERNEL_FLOOR_RST = 64'hffff_0000_0000_0000;

	// Field widths
	localparam int unsigned ADDR_W = 64;
	localparam int unsigned IDX_OUT_W = 12;

	// Stream widths: input tdata holds start, end, base, executable, file_backed,
	// address; output tdata holds the map offset and region_index
	localparam int unsigned S_TDATA_W = 264;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 80;
	localparam int unsigned M_TUSER_W = 3;

	// Action codes carried in s_tuser (code 3 is unused)
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_RESOLVE = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	// Result status codes
	typedef enum logic [2:0] {
		ST_LOADED   = 3'd0,
		ST_FILTERED = 3'd1,
		ST_FULL     = 3'd2,
		ST_CLEARED  = 3'd3,
		ST_NULL     = 3'd4,
		ST_MAPPED   = 3'd5,
		ST_KERNEL   = 3'd6,
		ST_UNKNOWN  = 3'd7
	} status_t;

	// Source of the region_index field of a result
	typedef enum logic [1:0] {
		IDX_ZERO  = 2'd0,
		IDX_COUNT = 2'd1,
		IDX_HIT   = 2'd2
	} idx_sel_t;

	// One region table entry
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] stop;
		logic [ADDR_W-1:0] base;
	} region_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     capture;
		logic     append;
		logic     clear;
		logic     scan_start;
		logic     scan;
		logic     latch_hit;
		logic     emit;
		status_t  status;
		idx_sel_t idx_sel;
		logic     use_offset;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] action;
		logic       full;
		logic       admit;
		logic       addr_zero;
		logic       count_zero;
		logic       above_floor;
		logic       hit;
		logic       scan_end;
		logic       out_free;
	} dp_stat_t;

endpackage

### sv/crat_ctrl.sv
// Controller state machine of the code region address translation block.
// Depends on crat_pkg; drives crat_dp through ctrl_cmd_t and reads dp_stat_t.
module crat_ctrl
	import crat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_HIT    = 5'b01000,
		S_MISS   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.status = ST_LOADED;
		cmd.idx_sel = IDX_ZERO;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (stat.action)
					ACT_LOAD: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							state_d = S_IDLE;
							if (stat.full) begin
								cmd.status = ST_FULL;
							end else if (!stat.admit) begin
								cmd.status = ST_FILTERED;
							end else begin
								cmd.status = ST_LOADED;
								cmd.append = 1'b1;
								cmd.idx_sel = IDX_COUNT;
							end
						end
					end
					ACT_RESOLVE: begin
						if (stat.addr_zero) begin
							if (stat.out_free) begin
								cmd.emit = 1'b1;
								cmd.status = ST_NULL;
								state_d = S_IDLE;
							end
						end else if (stat.count_zero) begin
							state_d = S_MISS;
						end else begin
							cmd.scan_start = 1'b1;
							state_d = S_SCAN;
						end
					end
					ACT_CLEAR: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.clear = 1'b1;
							cmd.status = ST_CLEARED;
							state_d = S_IDLE;
						end
					end
					default: begin
						// unused action: no result
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				// first hit in table order wins
				cmd.scan = 1'b1;
				if (stat.hit) begin
					cmd.latch_hit = 1'b1;
					state_d = S_HIT;
				end else if (stat.scan_end) begin
					state_d = S_MISS;
				end
			end
			S_HIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.status = ST_MAPPED;
					cmd.idx_sel = IDX_HIT;
					cmd.use_offset = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MISS: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.status = stat.above_floor ? ST_KERNEL : ST_UNKNOWN;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/crat_dp.sv
// Datapath of the code region address translation block: request latch,
// region memory, scan compare pipeline, offset adder and output register.
// Depends on crat_pkg; commanded by crat_ctrl.
module crat_dp
	import crat_pkg::*;
#(
	parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,
	input  logic                 cfg_we,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             stat
);

	localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

	// Request latch
	logic [1:0]        action_q;
	region_t           req_q;
	logic              exec_q;
	logic              file_q;
	logic [ADDR_W-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q    <= s_tuser[1:0];
			req_q.start <= s_tdata[63:0];
			req_q.stop  <= s_tdata[127:64];
			req_q.base  <= s_tdata[191:128];
			exec_q      <= s_tdata[192];
			file_q      <= s_tdata[193];
			addr_q      <= s_tdata[257:194];
		end
	end

	// Kernel floor register
	logic [ADDR_W-1:0] kernel_floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_floor_q <= KERNEL_FLOOR_RST;
		end else if (cfg_we) begin
			kernel_floor_q <= cfg_wdata;
		end
	end

	// Region count and scan pointer
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             issue;

	assign issue = cmd.scan && (scan_idx_q < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			rd_vld_s1 <= issue;
		end
	end

	// Region memory: one write port, one registered read port
	region_t region_mem [MAX_REGIONS];
	region_t rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			region_mem[count_q[IDX_W-1:0]] <= req_q;
		end
		rd_s1  <= region_mem[scan_idx_q[IDX_W-1:0]];
		idx_s1 <= scan_idx_q[IDX_W-1:0];
	end

	// Compare stage
	logic match;

	assign match = (addr_q >= rd_s1.start) && (addr_q < rd_s1.stop);

	// Hit capture: partial offset and slot
	logic [ADDR_W-1:0] diff_q;
	logic [ADDR_W-1:0] base_q;
	logic [IDX_W-1:0]  hit_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_hit) begin
			diff_q    <= addr_q - rd_s1.start;
			base_q    <= rd_s1.base;
			hit_idx_q <= idx_s1;
		end
	end

	// Output register
	logic              out_vld_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_offset_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [IDX_OUT_W-1:0] idx_mux;

	always_comb begin
		unique case (cmd.idx_sel)
			IDX_COUNT: idx_mux = IDX_OUT_W'(count_q);
			IDX_HIT:   idx_mux = IDX_OUT_W'(hit_idx_q);
			default:   idx_mux = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.status;
			out_offset_q <= cmd.use_offset ? (diff_q + base_q) : '0;
			out_idx_q    <= idx_mux;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0, out_idx_q, out_offset_q};

	// Status to controller
	assign stat.action      = action_q;
	assign stat.full        = (count_q == CNT_W'(MAX_REGIONS));
	assign stat.admit       = exec_q && file_q;
	assign stat.addr_zero   = (addr_q == '0);
	assign stat.count_zero  = (count_q == '0);
	assign stat.above_floor = (addr_q >= kernel_floor_q);
	assign stat.hit         = rd_vld_s1 && match;
	assign stat.scan_end    = rd_vld_s1 && (CNT_W'(idx_s1) == count_q - CNT_W'(1));
	assign stat.out_free    = !out_vld_q || m_tready;

endmodule

### sv/code_region_address_translate.sv
// Top level of the code region address translation block.
// Depends on crat_pkg, crat_ctrl and crat_dp.
//
// Channel  Dir  Signals                    Payload (low bit first)
// s_       in   s_tvalid/s_tready          tuser: action; tdata: region_start,
//                                          region_end, region_base, executable,
//                                          file_backed, address
// m_       out  m_tvalid/m_tready          tuser: status; tdata: map_offset,
//                                          region_index
// cfg_     in   cfg_we                     cfg_wdata: kernel_floor
//
// Load, clear and null resolve requests go from S_DECIDE straight to the result
// register; an unused action gives no result. A resolve that scans ends in S_HIT
// or S_MISS before its result is written: the region memory has one read port and
// the scan reads one entry per cycle, up to MAX_REGIONS entries.
// Reset empties the region count and reloads the floor default; no clearing pass.
// A new request is taken while a finished result still waits on m_tready.
module code_region_address_translate
	import crat_pkg::*;
#(
	parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // region_start, region_end, region_base,
	                                       // executable, file_backed, address, pad
	input  logic [S_TUSER_W-1:0] s_tuser,  // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // map_offset, region_index, pad
	output logic [M_TUSER_W-1:0] m_tuser,  // status
	input  logic                 cfg_we,
	input  logic [ADDR_W-1:0]    cfg_wdata
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	crat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crat_dp #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

`ifndef NO_ASSERTIONS
	// A waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> stat.out_free)
		else $error("result emitted over a pending result");

	// No append into a full table
	assert property (@(posedge clk) disable iff (!arst_n) cmd.append |-> !stat.full)
		else $error("append into full region table");

	// Clear empties the table
	assert property (@(posedge clk) disable iff (!arst_n) cmd.clear |=> stat.count_zero)
		else $error("region count not zero after clear");

	// Scan hits are never reported while the controller is idle
	assert property (@(posedge clk) disable iff (!arst_n) stat.hit |-> !s_tready)
		else $error("hit reported outside a scan");
`endif

endmodule
